// ===== hw/rtl/lcg_keystream_xor_cipher_assert.svh =====
// ----------------------------------------------------------------------------
// lcg_keystream_xor_cipher_assert.svh
// Assertion macros for the LCG keystream cipher. They sample on clk and are
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LCG_KEYSTREAM_XOR_CIPHER_ASSERT_SVH
`define LCG_KEYSTREAM_XOR_CIPHER_ASSERT_SVH

// Same-cycle implication
`define LCGX_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcgx: same-cycle check failed");

// Next-cycle implication
`define LCGX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcgx: next-cycle check failed");

`endif

// ===== hw/rtl/lcgx_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgx_pkg
// Shared types, constants and reduction functions of the LCG keystream
// cipher: minstd generator constants, reciprocal for mod 57, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgx_pkg;

    localparam int GEN_W   = 31;
    localparam int MULB_W  = 32;
    localparam int PROD_W  = GEN_W + MULB_W;
    localparam int KEY_W   = 64;
    localparam int BYTE_W  = 8;
    localparam int SHIFT_W = 6;
    localparam int QUOT_W  = 26;

    // minstd modulus 2^31-1 and multiplier
    localparam logic [GEN_W-1:0]  LCG_MODULUS = 31'h7fff_ffff;
    localparam logic [MULB_W-1:0] LCG_MULT    = 32'd48271;

    // x mod 57 via x - 57*floor(x*RECIP_57 >> 37); exact for x < 2^31
    localparam logic [GEN_W-1:0]  SHIFT_SPAN  = 31'd57;
    localparam logic [MULB_W-1:0] RECIP_57    = 32'd2411209711;
    localparam int                RECIP_SHIFT = 37;

    typedef logic [GEN_W-1:0]  gen_t;
    typedef logic [MULB_W-1:0] mulb_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_RED1,
        S_MUL2,
        S_RED2,
        S_MUL3,
        S_MOD
    } state_t;

    // Seed: low word of key ^ (key >> 32), mod 2^31-1, zero forced to one
    function automatic gen_t lcgx_seed(input key_t k);
        logic [31:0] v;
        logic [31:0] s;
        gen_t        r;
        v = k[31:0] ^ k[63:32];
        s = {1'b0, v[30:0]} + {31'd0, v[31]};
        if (s >= {1'b0, LCG_MODULUS})
        begin
            s = s - {1'b0, LCG_MODULUS};
        end
        r = s[GEN_W-1:0];
        if (r == '0)
        begin
            r = gen_t'(1);
        end
        return r;
    endfunction

    // x*48271 mod 2^31-1 from the raw product: fold high part onto low part
    function automatic gen_t lcgx_fold(input prod_t p);
        logic [31:0] s;
        s = {1'b0, p[GEN_W-1:0]} + {16'd0, p[46:GEN_W]};
        if (s >= {1'b0, LCG_MODULUS})
        begin
            s = s - {1'b0, LCG_MODULUS};
        end
        return s[GEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lcgx_mul.sv =====
// ----------------------------------------------------------------------------
// lcgx_mul
// Shared 31x32 multiplier with a registered product. Used for both generator
// draws and for the reciprocal step of the mod 57 reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgx_mul
(
    input  wire logic           clk,
    input  wire logic           mul_en,
    input  wire lcgx_pkg::gen_t  a,
    input  wire lcgx_pkg::mulb_t b,
    output lcgx_pkg::prod_t      prod
);
    import lcgx_pkg::*;

    prod_t prod_reg;

    // product register, loaded only when the sequencer issues a multiply
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= {{MULB_W{1'b0}}, a} * {{GEN_W{1'b0}}, b};
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lcg_keystream_xor_cipher.sv =====
// ----------------------------------------------------------------------------
// lcg_keystream_xor_cipher
// Byte XOR stream cipher driven by a minstd Lehmer generator seeded from key.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the 64-bit key; it is
//   always ready and is meant to be written while the block is idle. A key
//   write does not reseed: only an input beat with restart set does.
//   in channel (in_valid/in_ready, data_byte, restart) takes one byte per beat.
//   out channel (out_valid/out_ready, data_out) returns one byte per input beat.
// Sequencing:
//   A new byte is taken only in the idle state, so one byte is in flight at
//   a time. The sequence is set by the one shared multiplier, used three
//   times per byte (two draws, one mod 57 reciprocal step), each followed by
//   its product register and a reduction step.
// Reset: key clears to zero, the generator restarts at one, no beat pending.
// Stall: the output register holds its beat; the next byte can be taken
// meanwhile but its result waits in the last step until the slot frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lcg_keystream_xor_cipher_assert.svh"

module lcg_keystream_xor_cipher
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire lcgx_pkg::key_t  cfg_data,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire lcgx_pkg::byte_t data_byte,
    input  wire logic            restart,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lcgx_pkg::byte_t      data_out
);
    import lcgx_pkg::*;

    state_t state_reg, state_next;
    gen_t   gen_reg, gen_next;
    key_t   key_reg;
    byte_t  data_reg, data_next;
    byte_t  first_reg, first_next;
    byte_t  out_reg, out_next;
    logic   out_valid_reg, out_valid_next;

    logic   mul_en;
    mulb_t  mul_b;
    prod_t  prod;
    gen_t   fold_val;
    logic [QUOT_W-1:0] quot;
    gen_t   rem_full;
    logic [SHIFT_W-1:0] shift;
    key_t   key_shifted;

    // shared multiplier
    lcgx_mul u_mul
    (
        .clk    (clk),
        .mul_en (mul_en),
        .a      (gen_reg),
        .b      (mul_b),
        .prod   (prod)
    );

    // reductions of the registered product
    assign fold_val    = lcgx_fold(prod);
    assign quot        = prod[PROD_W-1:RECIP_SHIFT];
    assign rem_full    = gen_reg - (gen_t'(quot) * SHIFT_SPAN);
    assign shift       = rem_full[SHIFT_W-1:0];
    assign key_shifted = key_reg >> shift;

    // key register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cfg_data;
        end
    end

    // control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gen_reg       <= gen_t'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        first_reg <= first_next;
        out_reg   <= out_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        data_next      = data_reg;
        first_next     = first_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mul_en         = 1'b0;
        mul_b          = LCG_MULT;
        in_ready       = 1'b0;

        // output slot drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    data_next  = data_byte;
                    if (restart)
                    begin
                        gen_next = lcgx_seed(key_reg);
                    end
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                mul_en     = 1'b1;
                state_next = S_RED1;
            end
            S_RED1:
            begin
                gen_next   = fold_val;
                first_next = fold_val[BYTE_W-1:0];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                mul_en     = 1'b1;
                state_next = S_RED2;
            end
            S_RED2:
            begin
                gen_next   = fold_val;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                mul_en     = 1'b1;
                mul_b      = RECIP_57;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                // wait here until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = data_reg ^ first_reg ^ key_shifted[BYTE_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign data_out  = out_reg;

    // checks
    `LCGX_ASSERT_IMPLY(a_gen_in_range, 1'b1, (gen_reg != '0) && (gen_reg != LCG_MODULUS))
    `LCGX_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_MUL1)
    `LCGX_ASSERT_IMPLY(a_shift_range, state_reg == S_MOD, rem_full < SHIFT_SPAN)
    `LCGX_ASSERT_NEXT(a_stall_holds, state_reg == S_MOD && out_valid_reg && !out_ready,
        state_reg == S_MOD)

endmodule

`default_nettype wire
